// File: rtl/aar_pkg.sv
package aar_pkg;

  localparam int FieldW = 16;
  localparam int CordW = 34;
  localparam int AngW = 14;
  localparam int SumW = 72;
  localparam int DefFracBits = 14;
  localparam int DefCordicStages = 16;

  localparam int HalfTurnQ = 11520;
  localparam int FullTurnQ = 23040;
  localparam int QuarterTurnQ = 5760;
  localparam int RadPerDegQ32 = 74961321;
  localparam int CordicGainInv = 652032874;
  localparam int OneQ30 = 1 << 30;

  // Data handed from one CORDIC cell to the next
  typedef struct packed {
    logic                     valid;
    logic                     neg_cos;
    logic signed [CordW-1:0]  x;
    logic signed [CordW-1:0]  y;
    logic signed [CordW-1:0]  z;
    logic signed [FieldW-1:0] ax;
    logic signed [FieldW-1:0] ay;
    logic signed [FieldW-1:0] az;
  } cell_t;

  // Arctangent of 2^-i in Q2.30, zero past the table
  function automatic logic signed [CordW-1:0] atan_q30(input int i);
    logic signed [CordW-1:0] v;
    case (i)
      0: v = 34'sd843314856;
      1: v = 34'sd497837829;
      2: v = 34'sd263043836;
      3: v = 34'sd133525158;
      4: v = 34'sd67021686;
      5: v = 34'sd33543515;
      6: v = 34'sd16775850;
      7: v = 34'sd8388437;
      8: v = 34'sd4194282;
      9: v = 34'sd2097149;
      10: v = 34'sd1048575;
      11: v = 34'sd524287;
      12: v = 34'sd262143;
      13: v = 34'sd131071;
      14: v = 34'sd65535;
      15: v = 34'sd32767;
      16: v = 34'sd16383;
      17: v = 34'sd8191;
      18: v = 34'sd4095;
      19: v = 34'sd2047;
      20: v = 34'sd1023;
      21: v = 34'sd511;
      22: v = 34'sd255;
      23: v = 34'sd127;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Round a Q(30+F) sum to Q2.F and saturate to 16 bits
  function automatic logic signed [FieldW-1:0] round_sat(input logic signed [SumW-1:0] sum);
    logic signed [SumW-1:0] v;
    logic signed [FieldW-1:0] r;
    v = (sum + SumW'(OneQ30 / 2)) >>> 30;
    if (v > SumW'(32767)) begin
      r = 16'sh7fff;
    end else if (v < -SumW'(32768)) begin
      r = 16'sh8000;
    end else begin
      r = v[FieldW-1:0];
    end
    return r;
  endfunction

endpackage

// File: rtl/aar_reduce.sv
module aar_reduce
  import aar_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     adv_i,
  input  logic                     in_valid_i,
  input  logic signed [FieldW-1:0] angle_deg_i,
  input  logic signed [FieldW-1:0] axis_x_i,
  input  logic signed [FieldW-1:0] axis_y_i,
  input  logic signed [FieldW-1:0] axis_z_i,
  output cell_t                    cell_o
);

  logic signed [FieldW:0]   r;
  logic                     neg_d;
  logic                     valid_q;
  logic                     neg_q;
  logic signed [AngW-1:0]   t_q;
  logic signed [FieldW-1:0] ax_q, ay_q, az_q;
  logic signed [43:0]       prod;
  cell_t                    cell_d, cell_q;

  // Fold the angle into plus or minus 90 degrees, flag a negated cosine
  always_comb begin
    r = (FieldW + 1)'(angle_deg_i);
    neg_d = 1'b0;
    if (r >= (FieldW + 1)'(FullTurnQ)) begin
      r = r - (FieldW + 1)'(FullTurnQ);
    end else if (r <= -(FieldW + 1)'(FullTurnQ)) begin
      r = r + (FieldW + 1)'(FullTurnQ);
    end
    if (r > (FieldW + 1)'(HalfTurnQ)) begin
      r = r - (FieldW + 1)'(FullTurnQ);
    end
    if (r <= -(FieldW + 1)'(HalfTurnQ)) begin
      r = r + (FieldW + 1)'(FullTurnQ);
    end
    if (r > (FieldW + 1)'(QuarterTurnQ)) begin
      r = (FieldW + 1)'(HalfTurnQ) - r;
      neg_d = 1'b1;
    end else if (r < -(FieldW + 1)'(QuarterTurnQ)) begin
      r = -(FieldW + 1)'(HalfTurnQ) - r;
      neg_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      t_q  <= r[AngW-1:0];
      neg_q <= neg_d;
      ax_q <= axis_x_i;
      ay_q <= axis_y_i;
      az_q <= axis_z_i;
    end
  end

  // Convert degrees to Q2.30 radians
  always_comb begin
    prod = 44'(t_q) * 44'(RadPerDegQ32);
    cell_d.valid   = valid_q;
    cell_d.neg_cos = neg_q;
    cell_d.x       = CordW'(CordicGainInv);
    cell_d.y       = '0;
    cell_d.z       = CordW'((prod + 44'sd128) >>> 8);
    cell_d.ax      = ax_q;
    cell_d.ay      = ay_q;
    cell_d.az      = az_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else if (adv_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

// File: rtl/aar_cordic_cell.sv
module aar_cordic_cell
  import aar_pkg::*;
#(
  parameter int Stage = 0
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  adv_i,
  input  cell_t cell_i,
  output cell_t cell_o
);

  logic signed [CordW-1:0] dx, dy, at;
  cell_t cell_d, cell_q;

  // Rotate one micro-step toward the remaining angle
  always_comb begin
    dx = cell_i.y >>> Stage;
    dy = cell_i.x >>> Stage;
    at = atan_q30(Stage);
    cell_d = cell_i;
    if (!cell_i.z[CordW-1]) begin
      cell_d.x = cell_i.x - dx;
      cell_d.y = cell_i.y + dy;
      cell_d.z = cell_i.z - at;
    end else begin
      cell_d.x = cell_i.x + dx;
      cell_d.y = cell_i.y - dy;
      cell_d.z = cell_i.z + at;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else if (adv_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

// File: rtl/aar_matrix.sv
module aar_matrix
  import aar_pkg::*;
#(
  parameter int FracBits = DefFracBits
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     adv_i,
  input  cell_t                    cell_i,
  output logic                     valid_o,
  output logic signed [FieldW-1:0] r_o [9]
);

  // Product order: xx, yy, zz, xy, xz, yz
  logic                     a_valid_q, b_valid_q, o_valid_q;
  logic signed [CordW-1:0]  c_d;
  logic signed [CordW-1:0]  c_q, s_q;
  logic signed [FieldW-1:0] ax_q, ay_q, az_q;
  logic signed [31:0]       aa_q [6];
  logic signed [CordW:0]    m;
  logic signed [SumW-1:0]   p_q [6];
  logic signed [SumW-1:0]   sx_q, sy_q, sz_q, cd_q;
  logic signed [FieldW-1:0] r_q [9];

  assign c_d = cell_i.neg_cos ? -cell_i.x : cell_i.x;
  assign m = (CordW + 1)'(OneQ30) - (CordW + 1)'(c_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else if (adv_i) begin
      a_valid_q <= cell_i.valid;
      b_valid_q <= a_valid_q;
      o_valid_q <= b_valid_q;
    end
  end

  // Form the axis outer products
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      c_q   <= c_d;
      s_q   <= cell_i.y;
      ax_q  <= cell_i.ax;
      ay_q  <= cell_i.ay;
      az_q  <= cell_i.az;
      aa_q[0] <= 32'(cell_i.ax) * 32'(cell_i.ax);
      aa_q[1] <= 32'(cell_i.ay) * 32'(cell_i.ay);
      aa_q[2] <= 32'(cell_i.az) * 32'(cell_i.az);
      aa_q[3] <= 32'(cell_i.ax) * 32'(cell_i.ay);
      aa_q[4] <= 32'(cell_i.ax) * 32'(cell_i.az);
      aa_q[5] <= 32'(cell_i.ay) * 32'(cell_i.az);
    end
  end

  // Scale by (1 - c) and s
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int k = 0; k < 6; k++) begin
        p_q[k] <= (SumW'(m) * SumW'(aa_q[k])) >>> FracBits;
      end
      sx_q <= SumW'(s_q) * SumW'(ax_q);
      sy_q <= SumW'(s_q) * SumW'(ay_q);
      sz_q <= SumW'(s_q) * SumW'(az_q);
      cd_q <= SumW'(c_q) <<< FracBits;
    end
  end

  // Sum, round and saturate each entry
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      r_q[0] <= round_sat(cd_q + p_q[0]);
      r_q[1] <= round_sat(p_q[3] - sz_q);
      r_q[2] <= round_sat(p_q[4] + sy_q);
      r_q[3] <= round_sat(p_q[3] + sz_q);
      r_q[4] <= round_sat(cd_q + p_q[1]);
      r_q[5] <= round_sat(p_q[5] - sx_q);
      r_q[6] <= round_sat(p_q[4] - sy_q);
      r_q[7] <= round_sat(p_q[5] + sx_q);
      r_q[8] <= round_sat(cd_q + p_q[2]);
    end
  end

  assign valid_o = o_valid_q;
  assign r_o = r_q;

endmodule

// File: rtl/axis_angle_rotation_matrix_top.sv
// Axis-angle to 3x3 rotation matrix.
// Input channel: in_valid_i / in_stall_o carry one request: angle in Q10.6
// degrees and a rotation axis in Q2.F (used as given, not normalized).
// Output channel: out_valid_o / out_stall_i carry the nine matrix entries,
// row-major, Q2.F, saturated to 16 bits.
// Pipeline: angle folding and degree-to-radian scaling, one register per CORDIC
// cell, then products, sums and rounding, each step registered.
// Throughput: one request per cycle when not stalled; stages form a register chain.
// Stall: while a result waits with out_stall_i high, the whole chain holds and
// in_stall_o rises, so no request enters until that result is taken.
// Reset: all valid flags clear; the block takes requests on the next cycle.
module axis_angle_rotation_matrix_top
  import aar_pkg::*;
#(
  parameter int FRAC_BITS = DefFracBits,
  parameter int CORDIC_STAGES = DefCordicStages
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [FieldW-1:0] angle_deg_i,
  input  logic signed [FieldW-1:0] axis_x_i,
  input  logic signed [FieldW-1:0] axis_y_i,
  input  logic signed [FieldW-1:0] axis_z_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [FieldW-1:0] r00_o,
  output logic signed [FieldW-1:0] r01_o,
  output logic signed [FieldW-1:0] r02_o,
  output logic signed [FieldW-1:0] r10_o,
  output logic signed [FieldW-1:0] r11_o,
  output logic signed [FieldW-1:0] r12_o,
  output logic signed [FieldW-1:0] r20_o,
  output logic signed [FieldW-1:0] r21_o,
  output logic signed [FieldW-1:0] r22_o
);

  logic                     adv;
  cell_t                    chain [CORDIC_STAGES+1];
  logic signed [FieldW-1:0] r [9];

  // Advance the chain unless a result waits on a stalled receiver
  assign adv = !out_valid_o || !out_stall_i;
  assign in_stall_o = !adv;

  aar_reduce u_reduce (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .in_valid_i  (in_valid_i),
    .angle_deg_i (angle_deg_i),
    .axis_x_i    (axis_x_i),
    .axis_y_i    (axis_y_i),
    .axis_z_i    (axis_z_i),
    .cell_o      (chain[0])
  );

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    aar_cordic_cell #(
      .Stage(g)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .cell_i (chain[g]),
      .cell_o (chain[g+1])
    );
  end

  aar_matrix #(
    .FracBits(FRAC_BITS)
  ) u_matrix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .cell_i  (chain[CORDIC_STAGES]),
    .valid_o (out_valid_o),
    .r_o     (r)
  );

  assign r00_o = r[0];
  assign r01_o = r[1];
  assign r02_o = r[2];
  assign r10_o = r[3];
  assign r11_o = r[4];
  assign r12_o = r[5];
  assign r20_o = r[6];
  assign r21_o = r[7];
  assign r22_o = r[8];

  // A stall toward the source comes only from a waiting, stalled result
  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a waiting result");

  // The last cell's request reaches the matrix stage on the next advance
  a_cell_to_matrix : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && chain[CORDIC_STAGES].valid) |=> u_matrix.a_valid_q)
    else $error("request lost between CORDIC chain and matrix stage");

  // Nothing new enters while the chain holds
  a_hold_chain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(chain[0]))
    else $error("chain moved while stalled");

endmodule
